@@ rtl/lea_pkg.sv @@
// ----------------------------------------------------------------------------
// lea_pkg
// Shared types, constants and helpers for the LEA-128 encryption block.
// ----------------------------------------------------------------------------
package lea_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 8;
  localparam int LANES  = 6;   // round-key words per round

  // round rotation amounts
  localparam int ROL_A = 9;
  localparam int ROR_B = 5;
  localparam int ROR_C = 3;

  // item kinds
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  typedef logic [WORD_W-1:0]            word_t;
  typedef logic [IDX_W-1:0]             kidx_t;
  typedef logic [3:0][WORD_W-1:0]       blk_t;
  typedef logic [LANES-1:0][WORD_W-1:0] rkeys_t;

  // one round-key word write toward the key store
  typedef struct packed {
    logic  we;
    kidx_t index;
    word_t word;
  } key_wr_t;

  // index / 6 for 8-bit values: reciprocal 171/1024 is exact below 256
  function automatic logic [5:0] div6(input kidx_t v);
    logic [15:0] p;
    p = 16'(v) * 16'd171;
    return p[15:10];
  endfunction

endpackage

@@ rtl/lea_ifs.sv @@
// ----------------------------------------------------------------------------
// lea_ifs
// Valid/ready channels for input items and ciphertext items.
// ----------------------------------------------------------------------------
interface lea_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [7:0]          key_index;
  logic [31:0]         key_word;
  logic [31:0]         block_word0;
  logic [31:0]         block_word1;
  logic [31:0]         block_word2;
  logic [31:0]         block_word3;

  modport source (output valid, kind, key_index, key_word,
                  block_word0, block_word1, block_word2, block_word3,
                  input ready);
  modport sink   (input valid, kind, key_index, key_word,
                  block_word0, block_word1, block_word2, block_word3,
                  output ready);
endinterface

interface lea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word0;
  logic [31:0] cipher_word1;
  logic [31:0] cipher_word2;
  logic [31:0] cipher_word3;

  modport source (output valid, cipher_word0, cipher_word1, cipher_word2,
                  cipher_word3, input ready);
  modport sink   (input valid, cipher_word0, cipher_word1, cipher_word2,
                  cipher_word3, output ready);
endinterface

@@ rtl/lea_key_store.sv @@
// ----------------------------------------------------------------------------
// lea_key_store
// Round-key memory: one row of six words per round, word-lane writes,
// registered full-row reads.
// ----------------------------------------------------------------------------
module lea_key_store #(
  parameter int NUM_ROUNDS = 24,
  parameter int RW         = 5
) (
  input  logic              clk,
  input  lea_pkg::key_wr_t  wr,
  input  logic [RW-1:0]     raddr,
  output lea_pkg::rkeys_t   rdata
);
  import lea_pkg::*;

  localparam kidx_t KEY_WORDS = IDX_W'(LANES * NUM_ROUNDS);

  rkeys_t mem [NUM_ROUNDS];

  logic [5:0]    q;
  kidx_t         rem;
  logic [RW-1:0] row;
  logic [2:0]    lane;
  logic          in_range;

  always_comb begin
    q        = div6(wr.index);
    rem      = wr.index - IDX_W'(16'(q) * 16'd6);
    row      = q[RW-1:0];
    lane     = rem[2:0];
    in_range = (wr.index < KEY_WORDS);
  end

  // out-of-range writes are dropped
  always_ff @(posedge clk) begin
    if (wr.we && in_range) begin
      mem[row][lane] <= wr.word;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lea_round.sv @@
// ----------------------------------------------------------------------------
// lea_round
// One LEA encryption round: three xor/add/rotate lanes and a word shift.
// ----------------------------------------------------------------------------
module lea_round (
  input  lea_pkg::blk_t   x,
  input  lea_pkg::rkeys_t k,
  output lea_pkg::blk_t   y
);
  import lea_pkg::*;

  word_t s0, s1, s2;

  always_comb begin
    s0   = (x[0] ^ k[0]) + (x[1] ^ k[1]);
    s1   = (x[1] ^ k[2]) + (x[2] ^ k[3]);
    s2   = (x[2] ^ k[4]) + (x[3] ^ k[5]);
    y[0] = (s0 << ROL_A) | (s0 >> (WORD_W - ROL_A));
    y[1] = (s1 >> ROR_B) | (s1 << (WORD_W - ROR_B));
    y[2] = (s2 >> ROR_C) | (s2 << (WORD_W - ROR_C));
    y[3] = x[0];
  end

endmodule

@@ rtl/lea128_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// lea128_block_encrypt
// LEA-128 block encryption with a loadable expanded round-key store.
// ----------------------------------------------------------------------------
// Usage:
//   req  : input items. kind = 0 writes key_word at key_index into the
//          round-key store (indexes at or above 6*NUM_ROUNDS are dropped);
//          no result. kind = 1 encrypts block_word0..3.
//   rsp  : one ciphertext item per block item, cipher_word0..3.
//   Result: a block's result is loaded into the rsp register when its
//   last round ends, and is offered on rsp from that register.
//   A new block is taken only once the last one has left the round loop;
//   the single round unit runs one round per cycle, with one key-store
//   row read per round.
//   Key items are taken one per cycle while no block is in flight.
//   req.ready is high only while no block is in flight.
//   A finished result sits in the rsp register; a following item is taken
//   meanwhile. If that block ends while rsp is still stalled, it waits in
//   the working register and req stays low until rsp frees.
//   Reset clears the sequencer and rsp.valid; the key store is not
//   cleared and must be loaded before any block item.
// ----------------------------------------------------------------------------
module lea128_block_encrypt #(
  parameter int NUM_ROUNDS = 24
) (
  input  logic        clk,
  input  logic        rst,
  lea_in_if.sink      req,
  lea_out_if.source   rsp
);
  import lea_pkg::*;

  localparam int RW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam logic [RW-1:0] LAST = RW'(NUM_ROUNDS - 1);

  typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

  state_t        state;
  logic [RW-1:0] round;
  blk_t          x;        // working words
  blk_t          y;        // round unit output
  blk_t          ct;       // result register
  logic          out_valid;
  logic          out_free;
  logic          ct_load;  // result register takes a finished block
  logic [RW-1:0] raddr;
  rkeys_t        keys;
  key_wr_t       kwr;

  // ready only between blocks
  assign req.ready = (state == IDLE);

  assign kwr.we    = req.valid && req.ready && (req.kind == KIND_KEY);
  assign kwr.index = req.key_index;
  assign kwr.word  = req.key_word;

  // row for the next round; row 0 is primed while idle so it is ready
  // on the first round after a block is taken
  assign raddr = (state == RUN && round != LAST) ? round + RW'(1) : '0;

  lea_key_store #(
    .NUM_ROUNDS (NUM_ROUNDS),
    .RW         (RW)
  ) u_keys (
    .clk   (clk),
    .wr    (kwr),
    .raddr (raddr),
    .rdata (keys)
  );

  lea_round u_round (
    .x (x),
    .k (keys),
    .y (y)
  );

  assign out_free = !out_valid || rsp.ready;
  assign ct_load  = out_free && ((state == RUN && round == LAST) || state == HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ct_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid && req.kind == KIND_BLOCK) begin
            x[0]  <= req.block_word0;
            x[1]  <= req.block_word1;
            x[2]  <= req.block_word2;
            x[3]  <= req.block_word3;
            round <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          if (round == LAST) begin
            if (out_free) begin
              ct    <= y;
              state <= IDLE;
            end else begin
              x     <= y;     // park result until rsp frees
              state <= HOLD;
            end
          end else begin
            x     <= y;
            round <= round + RW'(1);
          end
        end
        HOLD: begin
          if (out_free) begin
            ct    <= x;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.cipher_word0 = ct[0];
  assign rsp.cipher_word1 = ct[1];
  assign rsp.cipher_word2 = ct[2];
  assign rsp.cipher_word3 = ct[3];

  // a block starts its rounds at round zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_BLOCK) |=>
      (state == RUN && round == '0))
    else $error("block did not start at round zero");

  // key items never start the round loop
  a_key_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_KEY) |=> (state == IDLE))
    else $error("key item left idle");

  // the loop ends after the last round
  a_end: assert property (@(posedge clk) disable iff (rst)
    (state == RUN && round == LAST) |=> (state != RUN))
    else $error("round loop ran past last round");

  // a parked result only waits on a busy output register
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == HOLD) |-> out_valid)
    else $error("result parked with free output");

  // a new result comes only from the round loop or the parked result
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == RUN || $past(state) == HOLD))
    else $error("result appeared without a block");

endmodule
